// ===== src/mbet_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mbet_pkg;

    localparam int ROW_W      = 10;
    localparam int COL_W      = 11;
    localparam int COORD_W    = 32;
    localparam int STEP_W     = 29;
    localparam int CNT_W      = 16;
    localparam int SQ_W       = 34;
    localparam int FRAC       = 28;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SAT_W      = 42;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;
    localparam int Q_CW    = 2;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
    localparam coord_t COORD_MIN = 32'sh8000_0000;

    localparam logic [SQ_W-1:0] SQ_MAX = 34'h3_FFFF_FFFF;
    localparam logic [SQ_W:0]   BAIL   = 35'h0_4000_0000;

    localparam coord_t WIN_LO  = -32'sd536870912;
    localparam coord_t WIN_HI  = 32'sd536870912;
    localparam coord_t XD_OFF  = 32'sh0400_0000;
    localparam coord_t XP_OFF  = 32'sh1000_0000;
    localparam logic [35:0] BULB_R2 = 36'h0_0100_0000;

    localparam coord_t           RST_ORIGIN_RE = 32'shD800_0000;
    localparam coord_t           RST_ORIGIN_IM = 32'shF000_0000;
    localparam logic [STEP_W-1:0] RST_STEP_RE  = 29'd489335;
    localparam logic [STEP_W-1:0] RST_STEP_IM  = 29'd497102;
    localparam logic [CNT_W-1:0]  RST_LIMIT    = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_RE = 3'd0,
        CFG_ORIGIN_IM = 3'd1,
        CFG_STEP_RE   = 3'd2,
        CFG_STEP_IM   = 3'd3,
        CFG_ITER_LIM  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        coord_t              origin_re;
        coord_t              origin_im;
        logic [STEP_W-1:0]   step_re;
        logic [STEP_W-1:0]   step_im;
        logic [CNT_W-1:0]    iteration_limit;
    } cfg_t;

    typedef struct packed {
        coord_t c_re;
        coord_t c_im;
        logic   in_region;
    } item_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MULC,
        F_SUMC,
        F_SQR,
        F_QSUM,
        F_LHS,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_EVAL,
        B_MUL,
        B_DONE
    } back_state_t;

    function automatic coord_t sat_coord(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-COORD_W:0] upper;
        coord_t                 r;
        upper = v[SAT_W-1:COORD_W-1];
        if ((&upper) || (~|upper))
        begin
            r = v[COORD_W-1:0];
        end
        else if (v[SAT_W-1])
        begin
            r = COORD_MIN;
        end
        else
        begin
            r = COORD_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/mbet_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbet_fifo
    import mbet_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire item_t wr_data,
    output logic       full,
    input  wire logic  rd_en,
    output item_t      rd_data,
    output logic       empty
);

    item_t             mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_CW-1:0]   cnt_reg;
    logic              do_wr;
    logic              do_rd;

    assign full    = (cnt_reg == Q_CW'(Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= Q_CW'(Q_DEPTH))
        else $error("queue occupancy exceeds its depth");
`endif

endmodule

`default_nettype wire

// ===== src/mbet_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbet_front
    import mbet_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [ROW_W-1:0] pixel_row,
    input  wire logic [COL_W-1:0] pixel_col,
    output logic                  q_wr_en,
    output item_t                 q_wr_data,
    input  wire logic             q_full
);

    front_state_t       state_reg;
    front_state_t       state_next;

    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [39:0]        prod_re_reg;
    logic [38:0]        prod_im_reg;
    coord_t             c_re_reg;
    coord_t             c_im_reg;
    coord_t             xd_reg;
    logic               win_reg;
    logic [62:0]        p_yy_reg;
    logic [62:0]        p_xd_reg;
    logic [62:0]        p_xp_reg;
    logic [32:0]        q_reg;
    logic signed [34:0] b_reg;
    logic [30:0]        y2_reg;
    logic               bulb_reg;
    logic signed [52:0] ph_reg;
    logic signed [51:0] pl_reg;

    logic signed [SAT_W-1:0] sum_re;
    logic signed [SAT_W-1:0] sum_im;
    coord_t             xd;
    coord_t             xp;
    logic signed [63:0] m_yy;
    logic signed [63:0] m_xd;
    logic signed [63:0] m_xp;
    logic               win;
    logic [34:0]        xd2;
    logic [34:0]        y2;
    logic [34:0]        xp2;
    logic [35:0]        q_sum;
    logic [35:0]        bulb_sum;
    logic signed [34:0] b_val;
    logic signed [52:0] ph;
    logic signed [51:0] pl;
    logic signed [65:0] lhs;
    logic signed [65:0] rhs;
    logic               card;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    state_next = F_MULC;
                end
            end
            F_MULC: state_next = F_SUMC;
            F_SUMC: state_next = F_SQR;
            F_SQR:  state_next = F_QSUM;
            F_QSUM: state_next = F_LHS;
            F_LHS:  state_next = F_PUSH;
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        full    = (state_reg != F_IDLE);
        q_wr_en = (state_reg == F_PUSH) && !q_full;
    end

    always_comb
    begin
        sum_re = {{10{cfg.origin_re[31]}}, cfg.origin_re}
               + {14'b0, cfg.step_re[STEP_W-1:1]}
               + {2'b0, prod_re_reg};
        sum_im = {{10{cfg.origin_im[31]}}, cfg.origin_im}
               + {14'b0, cfg.step_im[STEP_W-1:1]}
               + {3'b0, prod_im_reg};

        xd   = c_re_reg - XD_OFF;
        xp   = c_re_reg + XP_OFF;
        m_yy = c_im_reg * c_im_reg;
        m_xd = xd * xd;
        m_xp = xp * xp;
        win  = (c_re_reg >= WIN_LO) && (c_re_reg <= WIN_HI)
            && (c_im_reg >= WIN_LO) && (c_im_reg <= WIN_HI);

        xd2      = p_xd_reg[62:FRAC];
        y2       = p_yy_reg[62:FRAC];
        xp2      = p_xp_reg[62:FRAC];
        q_sum    = {1'b0, xd2} + {1'b0, y2};
        bulb_sum = {1'b0, xp2} + {1'b0, y2};
        b_val    = {2'b0, q_sum[32:0]} + {{3{xd_reg[31]}}, xd_reg};

        ph = $signed({1'b0, q_reg[32:16]}) * b_reg;
        pl = $signed({1'b0, q_reg[15:0]}) * b_reg;

        lhs  = ({{13{ph_reg[52]}}, ph_reg} <<< 16) + {{14{pl_reg[51]}}, pl_reg};
        rhs  = {9'b0, y2_reg, 26'b0};
        card = (lhs < rhs);

        q_wr_data.c_re      = c_re_reg;
        q_wr_data.c_im      = c_im_reg;
        q_wr_data.in_region = win_reg && (card || bulb_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
            begin
                row_reg <= pixel_row;
                col_reg <= pixel_col;
            end
            F_MULC:
            begin
                prod_re_reg <= col_reg * cfg.step_re;
                prod_im_reg <= row_reg * cfg.step_im;
            end
            F_SUMC:
            begin
                c_re_reg <= sat_coord(sum_re);
                c_im_reg <= sat_coord(sum_im);
            end
            F_SQR:
            begin
                win_reg  <= win;
                xd_reg   <= xd;
                p_yy_reg <= m_yy[62:0];
                p_xd_reg <= m_xd[62:0];
                p_xp_reg <= m_xp[62:0];
            end
            F_QSUM:
            begin
                q_reg    <= q_sum[32:0];
                b_reg    <= b_val;
                y2_reg   <= y2[30:0];
                bulb_reg <= (bulb_sum < BULB_R2);
            end
            F_LHS:
            begin
                ph_reg <= ph;
                pl_reg <= pl;
            end
            F_PUSH:
            begin
            end
            default:
            begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> state_reg == F_MULC)
        else $error("accepted pixel did not start coordinate mapping");
`endif

endmodule

`default_nettype wire

// ===== src/mbet_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbet_back
    import mbet_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire item_t            q_rd_data,
    input  wire logic             q_empty,
    output logic                  q_rd_en,
    output logic                  empty,
    input  wire logic             pop,
    output logic [CNT_W-1:0]      escape_count,
    output logic [SQ_W-1:0]       final_re_sq,
    output logic [SQ_W-1:0]       final_im_sq
);

    back_state_t        state_reg;
    back_state_t        state_next;

    coord_t             c_re_reg;
    coord_t             c_im_reg;
    coord_t             zr_reg;
    coord_t             zi_reg;
    logic [62:0]        prr_reg;
    logic [62:0]        pii_reg;
    logic signed [63:0] pzz_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [SQ_W-1:0]    re2_reg;
    logic [SQ_W-1:0]    im2_reg;
    logic               res_valid_reg;
    logic [CNT_W-1:0]   res_count_reg;
    logic [SQ_W-1:0]    res_re2_reg;
    logic [SQ_W-1:0]    res_im2_reg;

    logic [SQ_W-1:0]         r2;
    logic [SQ_W-1:0]         i2;
    logic [SQ_W:0]           mag;
    logic                    go;
    logic signed [SAT_W-1:0] t_sum;
    logic signed [63:0]      zz_sh;
    logic signed [SAT_W-1:0] zi_sum;
    logic signed [63:0]      m_rr;
    logic signed [63:0]      m_ii;
    logic signed [63:0]      m_ri;
    logic                    res_load;

    always_comb
    begin
        r2     = prr_reg[62] ? SQ_MAX : prr_reg[61:FRAC];
        i2     = pii_reg[62] ? SQ_MAX : pii_reg[61:FRAC];
        mag    = {1'b0, r2} + {1'b0, i2};
        go     = (mag < BAIL) && (count_reg < cfg.iteration_limit);
        t_sum  = {8'b0, r2} - {8'b0, i2} + {{10{c_re_reg[31]}}, c_re_reg};
        zz_sh  = pzz_reg >>> (FRAC - 1);
        zi_sum = zz_sh[SAT_W-1:0] + {{10{c_im_reg[31]}}, c_im_reg};
        m_rr   = zr_reg * zr_reg;
        m_ii   = zi_reg * zi_reg;
        m_ri   = zr_reg * zi_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_EVAL;
                end
            end
            B_EVAL:
            begin
                if (go)
                begin
                    state_next = B_MUL;
                end
                else
                begin
                    state_next = B_DONE;
                end
            end
            B_MUL: state_next = B_EVAL;
            B_DONE:
            begin
                if (!res_valid_reg || pop)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_rd_en  = (state_reg == B_IDLE) && !q_empty;
        res_load = (state_reg == B_DONE) && (!res_valid_reg || pop);
        empty        = !res_valid_reg;
        escape_count = res_count_reg;
        final_re_sq  = res_re2_reg;
        final_im_sq  = res_im2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                c_re_reg  <= q_rd_data.c_re;
                c_im_reg  <= q_rd_data.c_im;
                zr_reg    <= '0;
                zi_reg    <= '0;
                prr_reg   <= '0;
                pii_reg   <= '0;
                pzz_reg   <= '0;
                count_reg <= q_rd_data.in_region ? cfg.iteration_limit : '0;
            end
            B_EVAL:
            begin
                re2_reg <= r2;
                im2_reg <= i2;
                if (go)
                begin
                    zr_reg    <= sat_coord(t_sum);
                    zi_reg    <= sat_coord(zi_sum);
                    count_reg <= count_reg + 1'b1;
                end
            end
            B_MUL:
            begin
                prr_reg <= m_rr[62:0];
                pii_reg <= m_ii[62:0];
                pzz_reg <= m_ri;
            end
            B_DONE:
            begin
                if (res_load)
                begin
                    res_count_reg <= count_reg;
                    res_re2_reg   <= re2_reg;
                    res_im2_reg   <= im2_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != B_IDLE |-> count_reg <= cfg.iteration_limit)
        else $error("iteration count passed the limit");

    a_done_reason: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_DONE |->
            (({1'b0, re2_reg} + {1'b0, im2_reg}) >= BAIL)
            || (count_reg == cfg.iteration_limit))
        else $error("iteration stopped without bailout or limit");

    a_mul_eval: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_MUL |=> state_reg == B_EVAL)
        else $error("product stage not followed by evaluation");
`endif

endmodule

`default_nettype wire

// ===== src/mandelbrot_escape_time_pixel_top.sv =====
// Front end: takes a pixel only when idle; MULC, SUMC, SQR, QSUM and LHS map it to c
// and run the window, cardioid and bulb test, and PUSH waits while the queue is full.
// Back end: one pixel at a time, by an iteration loop that alternates the three 32x32
// multipliers (MUL) and the update and bailout compare (EVAL).
// A two-entry queue between them and an output register let both sides stall.
// Reset is asynchronous, active low; control registers take defaults, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time_pixel_top
    import mbet_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [ROW_W-1:0]      pixel_row,
    input  wire logic [COL_W-1:0]      pixel_col,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [CNT_W-1:0]           escape_count,
    output logic [SQ_W-1:0]            final_re_sq,
    output logic [SQ_W-1:0]            final_im_sq,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  q_wr_en;
    item_t q_wr_data;
    logic  q_full;
    logic  q_rd_en;
    item_t q_rd_data;
    logic  q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_re       <= RST_ORIGIN_RE;
            cfg_reg.origin_im       <= RST_ORIGIN_IM;
            cfg_reg.step_re         <= RST_STEP_RE;
            cfg_reg.step_im         <= RST_STEP_IM;
            cfg_reg.iteration_limit <= RST_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ORIGIN_RE: cfg_reg.origin_re       <= cfg_data;
                CFG_ORIGIN_IM: cfg_reg.origin_im       <= cfg_data;
                CFG_STEP_RE:   cfg_reg.step_re         <= cfg_data[STEP_W-1:0];
                CFG_STEP_IM:   cfg_reg.step_im         <= cfg_data[STEP_W-1:0];
                CFG_ITER_LIM:  cfg_reg.iteration_limit <= cfg_data[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mbet_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .full      (full),
        .pixel_row (pixel_row),
        .pixel_col (pixel_col),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data),
        .q_full    (q_full)
    );

    mbet_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    mbet_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_rd_data    (q_rd_data),
        .q_empty      (q_empty),
        .q_rd_en      (q_rd_en),
        .empty        (empty),
        .pop          (pop),
        .escape_count (escape_count),
        .final_re_sq  (final_re_sq),
        .final_im_sq  (final_im_sq)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import mbet_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int          HOLD_CYCLES = 600;
    localparam longint      Q_ONE       = 64'sd1 <<< FRAC;
    localparam longint      BAILOUT     = 64'sd4 <<< FRAC;
    localparam longint      SQ_TOP      = 64'sh3_FFFF_FFFF;
    localparam longint      C_HI        = 64'sd2147483647;
    localparam longint      C_LO        = -64'sd2147483648;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } pixel_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SQ_W-1:0]  re_sq;
        logic [SQ_W-1:0]  im_sq;
    } escape_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [ROW_W-1:0]      pixel_row = '0;
    logic [COL_W-1:0]      pixel_col = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [CNT_W-1:0]      escape_count;
    logic [SQ_W-1:0]       final_re_sq;
    logic [SQ_W-1:0]       final_im_sq;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = CFG_ORIGIN_RE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic signed [COORD_W-1:0] view_origin_re = -32'sd671088640;
    logic signed [COORD_W-1:0] view_origin_im = -32'sd268435456;
    logic [STEP_W-1:0]         view_step_re   = 29'd489335;
    logic [STEP_W-1:0]         view_step_im   = 29'd497102;
    logic [CNT_W-1:0]          view_limit     = 16'd1000;

    pixel_t  pend_pix[$];
    escape_t expected_pix[$];

    int          err_cnt = 0;
    int          n_checked = 0;
    int          n_views = 0;
    int          hold_left = 0;
    int unsigned cycle_cnt = 0;
    bit          src_calm = 1'b0;
    bit          sink_calm = 1'b0;
    bit          sink_hold_req = 1'b0;
    bit          sink_hold_taken = 1'b0;

    mandelbrot_escape_time_pixel_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel_row    (pixel_row),
        .pixel_col    (pixel_col),
        .empty        (empty),
        .pop          (pop),
        .escape_count (escape_count),
        .final_re_sq  (final_re_sq),
        .final_im_sq  (final_im_sq),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic longint clamp_coord(input longint v);
        if (v > C_HI)
        begin
            return C_HI;
        end
        if (v < C_LO)
        begin
            return C_LO;
        end
        return v;
    endfunction

    function automatic longint sq_fix(input longint z);
        longint unsigned m;
        longint unsigned s;
        m = (z < 0) ? -z : z;
        s = (m * m) >> FRAC;
        if (s > SQ_TOP)
        begin
            s = SQ_TOP;
        end
        return longint'(s);
    endfunction

    function automatic bit in_cardioid_or_bulb(input longint x, input longint y);
        longint two;
        longint xd;
        longint y2;
        longint q;
        longint lhs;
        two = Q_ONE * 2;
        if (x < -two || x > two || y < -two || y > two)
        begin
            return 1'b0;
        end
        xd  = x - (Q_ONE >>> 2);
        y2  = sq_fix(y);
        q   = sq_fix(xd) + y2;
        lhs = q * (q + xd);
        if (lhs < (y2 <<< (FRAC - 2)))
        begin
            return 1'b1;
        end
        return (sq_fix(x + Q_ONE) + y2) < (Q_ONE >>> 4);
    endfunction

    function automatic escape_t escape_time(input logic [ROW_W-1:0] row,
                                            input logic [COL_W-1:0] col);
        longint  org_re;
        longint  org_im;
        longint  sr;
        longint  si;
        longint  c_re;
        longint  c_im;
        longint  zr;
        longint  zi;
        longint  t;
        longint  re2;
        longint  im2;
        longint  lim;
        longint  count;
        longint  rr;
        longint  cc;
        escape_t r;
        org_re = view_origin_re;
        org_im = view_origin_im;
        sr     = view_step_re;
        si     = view_step_im;
        lim    = view_limit;
        rr     = row;
        cc     = col;
        c_re   = clamp_coord(org_re + (sr >>> 1) + cc * sr);
        c_im   = clamp_coord(org_im + (si >>> 1) + rr * si);
        zr     = 0;
        zi     = 0;
        re2    = 0;
        im2    = 0;
        count  = 0;
        if (in_cardioid_or_bulb(c_re, c_im))
        begin
            count = lim;
        end
        while ((re2 + im2) < BAILOUT && count < lim)
        begin
            t     = clamp_coord(re2 - im2 + c_re);
            zi    = clamp_coord(((zr * zi) >>> (FRAC - 1)) + c_im);
            zr    = t;
            re2   = sq_fix(zr);
            im2   = sq_fix(zi);
            count = count + 1;
        end
        r.count = count[CNT_W-1:0];
        r.re_sq = re2[SQ_W-1:0];
        r.im_sq = im2[SQ_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (err_cnt < 30)
        begin
            $display("MISMATCH at cycle %0d: %s", cycle_cnt, what);
        end
        err_cnt++;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ORIGIN_RE: view_origin_re = data;
            CFG_ORIGIN_IM: view_origin_im = data;
            CFG_STEP_RE:   view_step_re   = data[STEP_W-1:0];
            CFG_STEP_IM:   view_step_im   = data[STEP_W-1:0];
            CFG_ITER_LIM:  view_limit     = data[CNT_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic set_view(input logic [31:0] o_re, input logic [31:0] o_im,
                            input logic [31:0] s_re, input logic [31:0] s_im,
                            input logic [31:0] lim);
        write_reg(CFG_ORIGIN_RE, o_re);
        write_reg(CFG_ORIGIN_IM, o_im);
        write_reg(CFG_STEP_RE, s_re);
        write_reg(CFG_STEP_IM, s_im);
        write_reg(CFG_ITER_LIM, lim);
        n_views++;
    endtask

    task automatic queue_pix(input int row, input int col);
        pixel_t p;
        p.row = ROW_W'(row);
        p.col = COL_W'(col);
        pend_pix.push_back(p);
    endtask

    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (pend_pix.size() != 0 || expected_pix.size() != 0 || push);
    endtask

    function automatic logic [31:0] random_step();
        logic [31:0] s;
        case ($urandom_range(0, 9))
            0:       s = $urandom();
            1, 2:    s = $urandom_range(1, 4096);
            default: s = $urandom_range(1, 1 << 18) | ($urandom_range(0, 7) << 29);
        endcase
        return s;
    endfunction

    always @(posedge clk)
    begin : pixel_feeder
        pixel_t done;
        if (rst_n)
        begin
            if (push && !full)
            begin
                expected_pix.push_back(escape_time(pixel_row, pixel_col));
                done = pend_pix.pop_front();
            end
            if (!(push && full))
            begin
                if (pend_pix.size() != 0 && (src_calm || $urandom_range(0, 99) >= 24))
                begin
                    push      <= 1'b1;
                    pixel_row <= pend_pix[0].row;
                    pixel_col <= pend_pix[0].col;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_checker
        escape_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_pix.size() == 0)
                begin
                    report_mismatch("result transaction with no pixel outstanding");
                end
                else
                begin
                    want = expected_pix.pop_front();
                    n_checked++;
                    if (escape_count !== want.count)
                    begin
                        report_mismatch($sformatf("escape_count got %0d want %0d",
                                                  escape_count, want.count));
                    end
                    if (final_re_sq !== want.re_sq)
                    begin
                        report_mismatch($sformatf("final_re_sq got %h want %h",
                                                  final_re_sq, want.re_sq));
                    end
                    if (final_im_sq !== want.im_sq)
                    begin
                        report_mismatch($sformatf("final_im_sq got %h want %h",
                                                  final_im_sq, want.im_sq));
                    end
                end
            end
            if (sink_hold_req && !sink_hold_taken)
            begin
                hold_left       = HOLD_CYCLES;
                sink_hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= sink_calm || ($urandom_range(0, 99) >= 24);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_cnt, expected_pix.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          k;
        int          n;
        logic [31:0] o_re;
        logic [31:0] o_im;
        logic [31:0] lim;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        queue_pix(0, 0);
        queue_pix(1023, 2047);
        queue_pix(0, 2047);
        queue_pix(1023, 0);
        queue_pix(540, 1207);
        queue_pix(540, 823);
        queue_pix(540, 406);
        queue_pix(540, 1508);
        drain();

        set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h1000_0000, 32'hF000_0000, 32'hFFFF_FFFF);
        @(negedge clk);
        queue_pix(0, 0);
        queue_pix(1023, 2047);
        queue_pix(512, 1024);
        queue_pix(1023, 0);
        drain();

        set_view(-32'sd475134771, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF);
        @(negedge clk);
        queue_pix(300, 600);
        drain();
        set_view(32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_FFFF);
        @(negedge clk);
        queue_pix(0, 0);
        queue_pix(1023, 2047);
        drain();

        set_view(-32'sd1073741824, 32'h0800_0000, 32'h0000_1000, 32'h0000_1000, 32'hABCD_0000);
        @(negedge clk);
        queue_pix(0, 0);
        queue_pix(1023, 2047);
        queue_pix(5, 7);
        drain();

        set_view(-32'sd536870912, 32'sd536870912, 32'h1, 32'h1, 32'h1);
        @(negedge clk);
        queue_pix(0, 0);
        queue_pix(1, 0);
        queue_pix(0, 1);
        queue_pix(1023, 2047);
        drain();

        for (k = 0; k < 15; k++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                o_re = $urandom();
            end
            else
            begin
                o_re = int'($urandom_range(0, 738197504)) - 603979776;
            end
            if ($urandom_range(0, 4) == 0)
            begin
                o_im = $urandom();
            end
            else
            begin
                o_im = int'($urandom_range(0, 671088640)) - 402653184;
            end
            if (k == 0)
            begin
                lim = 32'd1000;
            end
            else if (k == 1)
            begin
                lim = 32'd1 | ($urandom() & 32'hFFFF_0000);
            end
            else if (k == 5)
            begin
                lim = 32'd16;
            end
            else
            begin
                lim = $urandom_range(1, 64) | ($urandom() & 32'hFFFF_0000);
            end
            set_view(o_re, o_im, random_step(), random_step(), lim);
            src_calm  = (k == 3) || (k == 5);
            sink_calm = (k == 3);
            @(negedge clk);
            for (n = 0; n < 39; n++)
            begin
                queue_pix($urandom_range(0, 1023), $urandom_range(0, 2047));
            end
            if (k == 5)
            begin
                sink_hold_req = 1'b1;
            end
            drain();
        end
        src_calm  = 1'b0;
        sink_calm = 1'b0;

        repeat (300) @(posedge clk);
        $display("Checked %0d pixel results across %0d programmed views plus the reset view,",
                 n_checked, n_views);
        $display("including saturated, zero-step, zero-limit and window-edge views; %0d errors.",
                 err_cnt);
        if (err_cnt == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/mbet_pkg.sv
src/mbet_fifo.sv
src/mbet_front.sv
src/mbet_back.sv
src/mandelbrot_escape_time_pixel_top.sv
bench/tb.sv
